// File: hdl/sample_clock_timestamp_unit_core_assert.svh
// Assertion macros shared by the timestamp unit checker.
`ifndef SAMPLE_CLOCK_TIMESTAMP_UNIT_CORE_ASSERT_SVH
`define SAMPLE_CLOCK_TIMESTAMP_UNIT_CORE_ASSERT_SVH

// Same-cycle implication; the consequent may itself begin with a delay operator.
`define SCTU_AST_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error(msg);

// Next-cycle implication.
`define SCTU_AST_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/sctu_pkg.sv
// Package: widths, constants and sequencer states of the sample clock timestamp unit.
package sctu_pkg;

  localparam int SAMPLE_BITS = 48;
  localparam int RATE_BITS   = 20;
  localparam int TIME_BITS   = 64;

  // Nanoseconds per second and the bits it needs
  localparam int NS_BITS = 30;
  localparam logic [NS_BITS-1:0] NS_PER_SEC = NS_BITS'(1000000000);

  // Elapsed count is multiplied in two halves
  localparam int LO_BITS   = SAMPLE_BITS / 2;
  localparam int HI_BITS   = SAMPLE_BITS - LO_BITS;
  localparam int MUL_BITS  = HI_BITS + NS_BITS;
  localparam int PROD_BITS = SAMPLE_BITS + NS_BITS;

  // Quotient plus rounding, wide enough to see a carry past 64 bits
  localparam int QX_BITS  = ((PROD_BITS > TIME_BITS) ? PROD_BITS : TIME_BITS) + 1;
  localparam int CNT_BITS = $clog2(PROD_BITS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM,
    ST_DIV,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } sctu_state_t;

endpackage

// File: hdl/sample_clock_timestamp_unit_core.sv
// Sample clock timestamp unit: device sample count to monotonic nanosecond time.
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------------
//  in      | in_valid, in_stall  | device_ok, sample_time, sample_rate, system_time_ns
//  out     | out_valid, out_stall| time_ns, locked
//
// Fallback or re-anchor: the sequencer goes from idle straight to the output load state.
// Derived time: multiply of the low and high halves, a dividend add, one divide step per
// dividend bit on the shared subtractor, rounding, anchor add and output load.
// A waiting result does not block the next transfer; a full, stalled output register holds
// the sequencer in its last state. Synchronous reset clears anchor, last time and out_valid.
module sample_clock_timestamp_unit_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             device_ok,
  input  logic [sctu_pkg::SAMPLE_BITS-1:0] sample_time,
  input  logic [sctu_pkg::RATE_BITS-1:0]   sample_rate,
  input  logic [sctu_pkg::TIME_BITS-1:0]   system_time_ns,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [sctu_pkg::TIME_BITS-1:0]   time_ns,
  output logic                             locked
);
  import sctu_pkg::*;

  sctu_state_t state, state_next;

  // Architectural state
  logic [TIME_BITS-1:0]   last_time;
  logic [SAMPLE_BITS-1:0] anchor_samples;
  logic [TIME_BITS-1:0]   anchor_time;
  logic [RATE_BITS-1:0]   anchor_rate;
  logic                   anchor_held;
  logic                   lock_flag;

  // Working registers
  logic [SAMPLE_BITS-1:0] elapsed;
  logic [MUL_BITS-1:0]    prod_lo;
  logic [MUL_BITS-1:0]    prod_hi;
  logic [PROD_BITS-1:0]   dvd;
  logic [RATE_BITS-1:0]   rem;
  logic [CNT_BITS-1:0]    cnt;
  logic [TIME_BITS-1:0]   scaled;
  logic [TIME_BITS-1:0]   cand;

  // Control
  logic accept;
  logic emit_go;
  logic fallback;
  logic reanchor;

  // Datapath nets
  logic [HI_BITS-1:0]     mul_a;
  logic [MUL_BITS-1:0]    mul_out;
  logic [RATE_BITS:0]     sub_a;
  logic [RATE_BITS+1:0]   sub_diff;
  logic                   sub_ge;
  logic [QX_BITS-1:0]     q_round;
  logic [TIME_BITS:0]     anchor_sum;
  logic [TIME_BITS-1:0]   clamped;

  // Request classification
  assign fallback = !device_ok || (sample_rate == '0);
  assign reanchor = !anchor_held || (sample_rate != anchor_rate) ||
                    (sample_time < anchor_samples);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (fallback || reanchor) ? ST_EMIT : ST_MUL_LO;
        end
      end
      ST_MUL_LO: state_next = ST_MUL_HI;
      ST_MUL_HI: state_next = ST_SUM;
      ST_SUM:    state_next = ST_DIV;
      ST_DIV: begin
        if (cnt == CNT_BITS'(1)) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND:  state_next = ST_ADD;
      ST_ADD:    state_next = ST_EMIT;
      ST_EMIT: begin
        if (emit_go) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_stall = 1'b1;
    emit_go  = 1'b0;
    unique case (state)
      ST_IDLE: in_stall = 1'b0;
      ST_EMIT: emit_go  = !out_valid || !out_stall;
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Shared multiplier: one half of the elapsed count times 1e9
  assign mul_a   = (state == ST_MUL_HI) ? elapsed[SAMPLE_BITS-1:LO_BITS]
                                        : HI_BITS'(elapsed[LO_BITS-1:0]);
  assign mul_out = MUL_BITS'(mul_a) * MUL_BITS'(NS_PER_SEC);

  // Shared subtractor: divide step, then the half-remainder compare
  assign sub_a    = (state == ST_ROUND) ? {rem, 1'b0} : {rem, dvd[PROD_BITS-1]};
  assign sub_diff = {1'b0, sub_a} - {2'b00, anchor_rate};
  assign sub_ge   = !sub_diff[RATE_BITS+1];

  // Rounded quotient, saturating to 64 bits
  assign q_round = QX_BITS'(dvd) + QX_BITS'(sub_ge);

  // Anchor plus scaled time, saturating
  assign anchor_sum = {1'b0, anchor_time} + {1'b0, scaled};

  // Never below the last emitted time
  assign clamped = (cand < last_time) ? last_time : cand;

  // Anchor and lock state
  always_ff @(posedge clk) begin
    if (rst) begin
      anchor_samples <= '0;
      anchor_time    <= '0;
      anchor_rate    <= '0;
      anchor_held    <= 1'b0;
      lock_flag      <= 1'b0;
      last_time      <= '0;
    end else begin
      if (accept) begin
        if (fallback) begin
          anchor_held <= 1'b0;
          lock_flag   <= 1'b0;
        end else begin
          lock_flag <= 1'b1;
          if (reanchor) begin
            anchor_samples <= sample_time;
            anchor_rate    <= sample_rate;
            anchor_time    <= (last_time != '0) ? last_time : system_time_ns;
            anchor_held    <= 1'b1;
          end
        end
      end
      if (emit_go) begin
        last_time <= clamped;
      end
    end
  end

  // Working datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        elapsed <= sample_time - anchor_samples;
        if (fallback) begin
          cand <= system_time_ns;
        end else begin
          cand <= (last_time != '0) ? last_time : system_time_ns;
        end
      end
      ST_MUL_LO: prod_lo <= mul_out;
      ST_MUL_HI: prod_hi <= mul_out;
      ST_SUM: begin
        dvd <= (PROD_BITS'(prod_hi) << LO_BITS) + PROD_BITS'(prod_lo);
        rem <= '0;
        cnt <= CNT_BITS'(PROD_BITS);
      end
      ST_DIV: begin
        rem <= sub_ge ? sub_diff[RATE_BITS-1:0] : sub_a[RATE_BITS-1:0];
        dvd <= {dvd[PROD_BITS-2:0], sub_ge};
        cnt <= cnt - CNT_BITS'(1);
      end
      ST_ROUND: begin
        scaled <= (|q_round[QX_BITS-1:TIME_BITS]) ? '1 : q_round[TIME_BITS-1:0];
      end
      ST_ADD: begin
        cand <= anchor_sum[TIME_BITS] ? '1 : anchor_sum[TIME_BITS-1:0];
      end
      ST_EMIT: begin
        if (emit_go) begin
          time_ns <= clamped;
          locked  <= lock_flag;
        end
      end
      default: begin
        cand <= cand;
      end
    endcase
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: hdl/sctu_checker.sv
// Port-level checker for the sample clock timestamp unit, with its bind.
`include "sample_clock_timestamp_unit_core_assert.svh"

module sctu_assert_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             device_ok,
  input logic [sctu_pkg::SAMPLE_BITS-1:0] sample_time,
  input logic [sctu_pkg::RATE_BITS-1:0]   sample_rate,
  input logic [sctu_pkg::TIME_BITS-1:0]   system_time_ns,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [sctu_pkg::TIME_BITS-1:0]   time_ns,
  input logic                             locked
);
  import sctu_pkg::*;

  // A held result keeps its payload
  `SCTU_AST_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(time_ns) && $stable(locked), "stalled result changed")

  // Timestamps never go backwards between loaded results
  `SCTU_AST_IMP(a_monotonic, out_valid && $past(out_valid), (time_ns >= $past(time_ns)), "timestamp went backwards")

  // One request at a time: busy right after a transfer
  `SCTU_AST_NEXT(a_busy_after_in, in_valid && !in_stall, in_stall, "took a second request while busy")

  // Fallback with a free output register shows an unlocked result once the output state loads it
  `SCTU_AST_IMP(a_fallback_unlocked, in_valid && !in_stall && !out_valid && (!device_ok || sample_rate == '0), ##2 (out_valid && !locked), "fallback result not unlocked")

endmodule

bind sample_clock_timestamp_unit_core sctu_assert_checker u_sctu_checker (.*);

// File: tb/sctu_checker.sv
`timescale 1ns / 100ps
// Checker for the timestamp unit: tracks requests, predicts timestamps, compares results.
module sctu_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic                             device_ok,
  input  logic [sctu_pkg::SAMPLE_BITS-1:0] sample_time,
  input  logic [sctu_pkg::RATE_BITS-1:0]   sample_rate,
  input  logic [sctu_pkg::TIME_BITS-1:0]   system_time_ns,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [sctu_pkg::TIME_BITS-1:0]   time_ns,
  input  logic                             locked,
  output int                               fail_count,
  output int                               pending_results
);
  import sctu_pkg::*;

  localparam int MAX_REPORTS = 10;
  // Product of elapsed samples and 1e9, with room to see a carry past 64 bits
  localparam int PROD_W = SAMPLE_BITS + NS_BITS;
  localparam int WIDE_BITS = ((PROD_W > TIME_BITS) ? PROD_W : TIME_BITS) + 2;

  typedef struct packed {
    logic [TIME_BITS-1:0] time_ns;
    logic                 locked;
  } stamp_t;

  // Predicted unit state
  logic [TIME_BITS-1:0]   last_stamp;
  logic [TIME_BITS-1:0]   anchor_ns;
  logic [SAMPLE_BITS-1:0] anchor_count;
  logic [RATE_BITS-1:0]   anchor_hz;
  logic                   anchored;
  logic                   clock_locked;

  stamp_t stamp_q[$];
  int     errors;

  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                   input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
  endfunction

  // elapsed * 1e9 / rate, rounded to nearest with halves up, saturated to 64 bits
  function automatic logic [TIME_BITS-1:0] samples_to_ns(input logic [SAMPLE_BITS-1:0] elapsed,
                                                         input logic [RATE_BITS-1:0] rate);
    logic [WIDE_BITS-1:0] product;
    logic [WIDE_BITS-1:0] quot;
    logic [WIDE_BITS-1:0] rem;
    product = WIDE_BITS'(elapsed) * WIDE_BITS'(NS_PER_SEC);
    quot    = product / WIDE_BITS'(rate);
    rem     = product % WIDE_BITS'(rate);
    if ((rem << 1) >= WIDE_BITS'(rate)) quot = quot + WIDE_BITS'(1);
    if (|quot[WIDE_BITS-1:TIME_BITS]) return '1;
    return quot[TIME_BITS-1:0];
  endfunction

  // Advance the predicted state by one request and return its timestamp
  function automatic stamp_t next_stamp(input logic                   ok,
                                        input logic [SAMPLE_BITS-1:0] samp,
                                        input logic [RATE_BITS-1:0]   rate,
                                        input logic [TIME_BITS-1:0]   sys);
    logic [TIME_BITS-1:0] t;
    stamp_t               s;
    if (!ok || rate == '0) begin
      // device unusable: fall back to system time
      clock_locked = 1'b0;
      anchored     = 1'b0;
      t            = sys;
    end else if (!anchored || rate != anchor_hz || samp < anchor_count) begin
      // re-anchor on the last emitted time, or system time if nothing emitted yet
      anchor_count = samp;
      anchor_ns    = (last_stamp != '0) ? last_stamp : sys;
      anchor_hz    = rate;
      anchored     = 1'b1;
      clock_locked = 1'b1;
      t            = anchor_ns;
    end else begin
      clock_locked = 1'b1;
      t            = sat_add(anchor_ns, samples_to_ns(samp - anchor_count, anchor_hz));
    end
    // never go backwards
    if (t < last_stamp) t = last_stamp;
    last_stamp = t;
    s.time_ns  = t;
    s.locked   = clock_locked;
    return s;
  endfunction

  task automatic flag_mismatch(input string what, input logic [TIME_BITS-1:0] want,
                               input logic [TIME_BITS-1:0] got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
  endtask

  // Compare result transfers, then queue the prediction for a request transfer
  always @(posedge clk) begin
    stamp_t want;
    if (rst) begin
      last_stamp   = '0;
      anchor_ns    = '0;
      anchor_count = '0;
      anchor_hz    = '0;
      anchored     = 1'b0;
      clock_locked = 1'b0;
      errors       = 0;
      stamp_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (stamp_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%t: result with none expected: time_ns %0d, locked %0b",
                     $time, time_ns, locked);
        end else begin
          want = stamp_q.pop_front();
          if (time_ns !== want.time_ns) flag_mismatch("time_ns", want.time_ns, time_ns);
          if (locked !== want.locked)
            flag_mismatch("locked", TIME_BITS'(want.locked), TIME_BITS'(locked));
        end
      end
      if (in_valid && !in_stall)
        stamp_q.push_back(next_stamp(device_ok, sample_time, sample_rate, system_time_ns));
    end
    fail_count      <= errors;
    pending_results <= stamp_q.size();
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Testbench top for the timestamp unit: request stimulus, result stalls and the verdict.
module testbench;
  import sctu_pkg::*;

  localparam int RANDOM_ITEMS = 500;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 120;

  logic                   clk            = 1'b0;
  logic                   rst            = 1'b1;
  logic                   in_valid       = 1'b0;
  logic                   device_ok      = 1'b0;
  logic [SAMPLE_BITS-1:0] sample_time    = '0;
  logic [RATE_BITS-1:0]   sample_rate    = '0;
  logic [TIME_BITS-1:0]   system_time_ns = '0;
  logic                   out_stall      = 1'b0;
  logic                   in_stall;
  logic                   out_valid;
  logic [TIME_BITS-1:0]   time_ns;
  logic                   locked;
  int                     fail_count;
  int                     pending_results;

  int                     cycle_count = 0;
  int                     burst_left  = 0;
  int                     stall_mode  = 0;
  int                     mode_left   = 0;
  logic [TIME_BITS-1:0]   sys_clock   = '0;

  always #2 clk = ~clk;

  sample_clock_timestamp_unit_core u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .device_ok      (device_ok),
    .sample_time    (sample_time),
    .sample_rate    (sample_rate),
    .system_time_ns (system_time_ns),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .time_ns        (time_ns),
    .locked         (locked)
  );

  sctu_checker u_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .device_ok       (device_ok),
    .sample_time     (sample_time),
    .sample_rate     (sample_rate),
    .system_time_ns  (system_time_ns),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .time_ns         (time_ns),
    .locked          (locked),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result side stalls: free-flowing, sparse random, or mostly stalled stretches
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      mode_left  <= $urandom_range(50, 400);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= ($urandom_range(0, 15) != 0);
    endcase
  end

  function automatic logic [SAMPLE_BITS-1:0] rand_count();
    return SAMPLE_BITS'({$urandom, $urandom});
  endfunction

  function automatic logic [TIME_BITS-1:0] rand_time();
    return TIME_BITS'({$urandom, $urandom});
  endfunction

  function automatic logic [RATE_BITS-1:0] pick_rate();
    case ($urandom_range(0, 7))
      0:       return RATE_BITS'(44100);
      1:       return RATE_BITS'(48000);
      2:       return RATE_BITS'(96000);
      3:       return RATE_BITS'(768000);
      4:       return RATE_BITS'(1);
      5:       return RATE_BITS'(1024);
      default: return RATE_BITS'($urandom_range(1, 768000));
    endcase
  endfunction

  // Sample counter advance between requests; bounded so the time stays well below 2^64
  function automatic logic [SAMPLE_BITS-1:0] count_step(input logic [RATE_BITS-1:0] hz);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return SAMPLE_BITS'(1);
      2, 3:    return SAMPLE_BITS'($urandom_range(1, 1000));
      4, 5:    return SAMPLE_BITS'($urandom_range(1, 32'(hz) * 2));
      6:       return SAMPLE_BITS'(hz);
      default: return SAMPLE_BITS'($urandom_range(1, 32'(hz) * 4096));
    endcase
  endfunction

  // System time moves forward, mostly in small steps
  function automatic logic [TIME_BITS-1:0] tick_system();
    if ($urandom_range(0, 15) == 0) sys_clock = sys_clock + (TIME_BITS'(1) << 36);
    else sys_clock = sys_clock + TIME_BITS'($urandom_range(0, 1 << 24));
    return sys_clock;
  endfunction

  // One request transfer; the sender runs in bursts with random gaps between them
  task automatic send_request(input logic                   ok,
                              input logic [SAMPLE_BITS-1:0] samp,
                              input logic [RATE_BITS-1:0]   rate,
                              input logic [TIME_BITS-1:0]   sys);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    device_ok      <= ok;
    sample_time    <= samp;
    sample_rate    <= rate;
    system_time_ns <= sys;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    logic [SAMPLE_BITS-1:0] count;
    logic [RATE_BITS-1:0]   hz;
    int                     run_len;
    int                     sent;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed requests
    sys_clock = {24'd0, 8'($urandom), $urandom};
    send_request(1'b0, '0, '0, '0);                            // fallback at zero
    send_request(1'b1, 48'd1000, 20'd48000, tick_system());    // first anchor on system time
    send_request(1'b1, 48'd49000, 20'd48000, tick_system());   // exactly one second
    send_request(1'b1, 48'd49001, 20'd48000, tick_system());   // fraction rounds down
    send_request(1'b1, 48'd50000, 20'd1024, tick_system());    // rate change re-anchors
    send_request(1'b1, 48'd50001, 20'd1024, tick_system());    // exact half rounds up
    send_request(1'b1, 48'd50003, 20'd1024, tick_system());
    send_request(1'b1, 48'd49990, 20'd1024, tick_system());    // counter goes backwards
    send_request(1'b1, 48'd49995, 20'd0, 64'd1);               // rate unreadable, clamped
    send_request(1'b0, rand_count(), 20'd768000, tick_system()); // device down
    send_request(1'b1, '1, 20'd768000, tick_system());         // anchor at counter top
    send_request(1'b1, '1, 20'd768000, tick_system());         // zero elapsed
    send_request(1'b1, '0, 20'd1, tick_system());              // rate and counter both jump
    send_request(1'b1, 48'd1, 20'd1, tick_system());
    send_request(1'b1, '0, 20'd768000, tick_system());
    send_request(1'b1, 48'd384, 20'd768000, tick_system());
    send_request(1'b1, 48'd767999, 20'd768000, tick_system());
    send_request(1'b0, '0, '0, 64'd0);                         // stale system time, clamped

    // Random part: mostly locked runs with random steps, plus noise and broken sequences
    count = '0;
    hz    = 20'd48000;
    sent  = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          if ($urandom_range(0, 2) == 0) begin
            // new counter origin: drop the device first so the jump re-anchors
            send_request(1'b0, rand_count(), pick_rate(), tick_system());
            count = rand_count();
            sent++;
          end
          if ($urandom_range(0, 1) == 0) hz = pick_rate();
          run_len = $urandom_range(3, 15);
          for (int i = 0; i < run_len; i++) begin
            send_request(1'b1, count, hz, tick_system());
            count = count + count_step(hz);
            sent++;
          end
        end
        7: begin
          send_request(1'($urandom_range(0, 1)), rand_count(),
                       ($urandom_range(0, 3) == 0) ? '0 : RATE_BITS'($urandom_range(1, 768000)),
                       tick_system() - TIME_BITS'($urandom_range(0, 1 << 30)));
          sent++;
        end
        8: begin
          send_request(1'b0, rand_count(), pick_rate(), tick_system());
          sent++;
        end
        default: begin
          send_request(1'b1, count - SAMPLE_BITS'($urandom_range(1, 1000)), hz, tick_system());
          sent++;
        end
      endcase
    end

    // Overflow cases last, since they pin the monotonic time at its ceiling
    send_request(1'b0, rand_count(), 20'd48000, 64'hFFFF_FFFF_FFFF_FC00);
    send_request(1'b1, '0, 20'd1, tick_system());              // anchor near the top
    send_request(1'b1, 48'd2, 20'd1, tick_system());           // anchor sum saturates
    send_request(1'b0, '0, 20'd1, tick_system());
    send_request(1'b1, '0, 20'd1, tick_system());
    send_request(1'b1, '1, 20'd1, tick_system());              // scaled time saturates
    for (int i = 0; i < 8; i++)
      send_request(1'($urandom_range(0, 1)), rand_count(),
                   RATE_BITS'($urandom_range(0, 768000)), rand_time());

    // Drain
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
